// ----- rtl/bcra_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap run allocator package
// Shared widths, word geometry, status codes and sequencer states.
// ----------------------------------------------------------------------------
package bcra_pkg;

   // Field widths of the request, response and configuration beats.
   localparam int FIRST_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int CFG_W    = 11;
   localparam int STATUS_W = 2;
   localparam int START_W  = 10;

   // The free map is held as words of SEG_BITS blocks; one word per cycle.
   localparam int SEG_BITS = 8;
   localparam int SEG_SH   = 3;

   localparam int MAP_BITS_DEF = 1024;
   localparam logic [CFG_W-1:0] TOTAL_RESET = 11'd1024;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_INVALID   = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MARK
   } state_type;

endpackage

// ----- rtl/bcra_map_mem.sv -----
// ----------------------------------------------------------------------------
// Free map memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bcra_map_mem #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [bcra_pkg::SEG_BITS-1:0] wr_data,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [bcra_pkg::SEG_BITS-1:0] rd_data
);
   import bcra_pkg::*;

   logic [SEG_BITS-1:0] mem [DEPTH];
   logic [SEG_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bcra_run_unit.sv -----
// ----------------------------------------------------------------------------
// Run tracking unit
// Extends the current free run across one map word and flags the first
// position at which the run reaches the requested length.
// ----------------------------------------------------------------------------
module bcra_run_unit #(
   parameter int CMP_W = 17
) (
   input  logic [bcra_pkg::SEG_BITS-1:0] seg,
   input  logic [CMP_W-1:0]             base,
   input  logic [CMP_W-1:0]             limit,
   input  logic [CMP_W-1:0]             need,
   input  logic [CMP_W-1:0]             len_in,
   input  logic [CMP_W-1:0]             begin_in,
   output logic                         found,
   output logic [CMP_W-1:0]             len_out,
   output logic [CMP_W-1:0]             begin_out
);
   import bcra_pkg::*;

   always_comb begin : run_walk
      logic [CMP_W-1:0] idx;
      logic [CMP_W-1:0] len;
      logic [CMP_W-1:0] beg;
      logic             fnd;
      len = len_in;
      beg = begin_in;
      fnd = 1'b0;
      for (int i = 0; i < SEG_BITS; i++) begin
         idx = base + CMP_W'(i);
         // Blocks at or past the usable limit are never part of a run.
         if (!fnd && (idx < limit)) begin
            if (seg[i]) begin
               if (len == '0) begin
                  beg = idx;
               end
               len = len + CMP_W'(1);
               if (len >= need) begin
                  fnd = 1'b1;
               end
            end else begin
               len = '0;
            end
         end
      end
      found     = fnd;
      len_out   = len;
      begin_out = beg;
   end

endmodule

// ----- rtl/bitmap_contiguous_run_allocator.sv -----
// ----------------------------------------------------------------------------
// Bitmap contiguous run allocator
// First-fit allocator over a free map of one bit per block (1 = free).
// ----------------------------------------------------------------------------
//
//  Channel    Ports                                   Handshake
//  --------   -------------------------------------   -----------------------
//  request    req_action, req_first_block, req_count  start high, busy low
//  response   rsp_status, rsp_alloc_base              rsp_valid, one cycle
//  config     csr_wdata (total_blocks)                csr_we, no wait
//
// The map is kept as words of eight blocks, walked one word a cycle by one run unit.
// After the accepting edge busy stays high while an allocate scans for a run and marks any
// run it finds, or while a free marks its words; it never rises on a zero count or a free
// past the usable end. The response strobe comes in the first cycle with busy low and
// cannot be stalled. Reset starts a one-word-a-cycle clearing pass.
// ----------------------------------------------------------------------------
module bitmap_contiguous_run_allocator #(
   parameter int MAP_BITS = bcra_pkg::MAP_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request beat.
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [bcra_pkg::FIRST_W-1:0]  req_first_block,
   input  logic [bcra_pkg::COUNT_W-1:0]  req_count,
   // Response beat.
   output logic                          rsp_valid,
   output logic [bcra_pkg::STATUS_W-1:0] rsp_status,
   output logic [bcra_pkg::START_W-1:0]  rsp_alloc_base,
   // Configuration.
   input  logic                          csr_we,
   input  logic [bcra_pkg::CFG_W-1:0]    csr_wdata
);
   import bcra_pkg::*;

   // Word geometry of the map.
   localparam int NUM_WORDS = (MAP_BITS + SEG_BITS - 1) / SEG_BITS;
   localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   // Block indexes and counts share one width: wide enough for MAP_BITS
   // itself and for first_block + count on a free.
   localparam int BIDX_W    = $clog2(MAP_BITS + 1);
   localparam int CMP_W     = (BIDX_W > 12) ? BIDX_W : 12;

   localparam logic [CMP_W-1:0]  MAP_BITS_C = CMP_W'(MAP_BITS);
   localparam logic [CMP_W-1:0]  SEG_STEP   = CMP_W'(SEG_BITS);
   localparam logic [CMP_W-1:0]  WORD_MASK  = ~CMP_W'(SEG_BITS - 1);
   localparam logic [ADDR_W-1:0] LAST_WORD  = ADDR_W'(NUM_WORDS - 1);

   // Sequencer and configuration state.
   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  total_ff, total_in;
   logic [ADDR_W-1:0] clr_ptr_ff, clr_ptr_in;
   logic              proc_ff, proc_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Working registers of the current beat.
   logic [CMP_W-1:0]  count_ff, count_in;
   logic [CMP_W-1:0]  rd_base_ff, rd_base_in;
   logic [CMP_W-1:0]  proc_base_ff, proc_base_in;
   logic [CMP_W-1:0]  run_len_ff, run_len_in;
   logic [CMP_W-1:0]  run_begin_ff, run_begin_in;
   logic [CMP_W-1:0]  mark_start_ff, mark_start_in;
   logic [CMP_W-1:0]  mark_last_ff, mark_last_in;
   logic              mark_val_ff, mark_val_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [START_W-1:0] rsp_start_ff, rsp_start_in;

   // Memory port and run unit connections.
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [SEG_BITS-1:0] mem_wdata;
   logic [ADDR_W-1:0]   mem_raddr;
   logic [SEG_BITS-1:0] mem_rdata;

   logic             unit_found;
   logic [CMP_W-1:0] unit_len;
   logic [CMP_W-1:0] unit_begin;

   logic [CMP_W-1:0]    total_ext;
   logic [CMP_W-1:0]    usable;
   logic [CMP_W-1:0]    free_end;
   logic [SEG_BITS-1:0] marked_word;
   logic                accept;

   // Registers above the map capacity are clamped to it.
   assign total_ext = CMP_W'(total_ff);
   assign usable    = (total_ext > MAP_BITS_C) ? MAP_BITS_C : total_ext;
   assign free_end  = CMP_W'(req_first_block) + CMP_W'(req_count);
   assign accept    = start && (state_ff == ST_IDLE);

   bcra_map_mem #(
      .DEPTH  (NUM_WORDS),
      .ADDR_W (ADDR_W)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   bcra_run_unit #(
      .CMP_W (CMP_W)
   ) u_run (
      .seg       (mem_rdata),
      .base      (proc_base_ff),
      .limit     (usable),
      .need      (count_ff),
      .len_in    (run_len_ff),
      .begin_in  (run_begin_ff),
      .found     (unit_found),
      .len_out   (unit_len),
      .begin_out (unit_begin)
   );

   // Rewrites the bits of the word in flight that fall inside the run.
   always_comb begin : mark_merge
      logic [CMP_W-1:0] idx;
      for (int i = 0; i < SEG_BITS; i++) begin
         idx = proc_base_ff + CMP_W'(i);
         if ((idx >= mark_start_ff) && (idx <= mark_last_ff)) begin
            marked_word[i] = mark_val_ff;
         end else begin
            marked_word[i] = mem_rdata[i];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      total_in      = csr_we ? csr_wdata : total_ff;
      clr_ptr_in    = clr_ptr_ff;
      proc_in       = 1'b0;
      rsp_valid_in  = 1'b0;
      count_in      = count_ff;
      rd_base_in    = rd_base_ff;
      proc_base_in  = rd_base_ff;
      run_len_in    = run_len_ff;
      run_begin_in  = run_begin_ff;
      mark_start_in = mark_start_ff;
      mark_last_in  = mark_last_ff;
      mark_val_in   = mark_val_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      mem_we        = 1'b0;
      mem_waddr     = proc_base_ff[SEG_SH +: ADDR_W];
      mem_wdata     = marked_word;
      mem_raddr     = rd_base_ff[SEG_SH +: ADDR_W];

      unique case (state_ff)
         ST_CLEAR: begin
            // One word a cycle is set to all free.
            mem_we     = 1'b1;
            mem_waddr  = clr_ptr_ff;
            mem_wdata  = '1;
            clr_ptr_in = clr_ptr_ff + ADDR_W'(1);
            if (clr_ptr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               count_in   = CMP_W'(req_count);
               run_len_in = '0;
               if (req_count == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_INVALID;
                  rsp_start_in  = '0;
               end else if (req_action == 1'b0) begin
                  rd_base_in = '0;
                  state_in   = ST_SCAN;
               end else if (free_end > usable) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_INVALID;
                  rsp_start_in  = '0;
               end else begin
                  mark_start_in = CMP_W'(req_first_block);
                  mark_last_in  = free_end - CMP_W'(1);
                  mark_val_in   = 1'b1;
                  rd_base_in    = CMP_W'(req_first_block) & WORD_MASK;
                  state_in      = ST_MARK;
               end
            end
         end

         ST_SCAN: begin
            // Prefetch the next word while the previous one is walked.
            proc_in    = 1'b1;
            rd_base_in = rd_base_ff + SEG_STEP;
            if (proc_ff) begin
               run_len_in   = unit_len;
               run_begin_in = unit_begin;
               if (unit_found) begin
                  mark_start_in = unit_begin;
                  mark_last_in  = unit_begin + count_ff - CMP_W'(1);
                  mark_val_in   = 1'b0;
                  rd_base_in    = unit_begin & WORD_MASK;
                  proc_in       = 1'b0;
                  state_in      = ST_MARK;
               end else if ((proc_base_ff + SEG_STEP) >= usable) begin
                  proc_in       = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NOT_FOUND;
                  rsp_start_in  = '0;
                  state_in      = ST_IDLE;
               end
            end
         end

         ST_MARK: begin
            // Read-modify-write, one word read and one written per cycle.
            if (rd_base_ff <= mark_last_ff) begin
               proc_in    = 1'b1;
               rd_base_in = rd_base_ff + SEG_STEP;
            end
            if (proc_ff) begin
               mem_we = 1'b1;
               if (rd_base_ff > mark_last_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_start_in  = mark_val_ff ? '0 : mark_start_ff[START_W-1:0];
                  state_in      = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         total_ff     <= TOTAL_RESET;
         clr_ptr_ff   <= '0;
         proc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         clr_ptr_ff   <= clr_ptr_in;
         proc_ff      <= proc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      rd_base_ff    <= rd_base_in;
      proc_base_ff  <= proc_base_in;
      run_len_ff    <= run_len_in;
      run_begin_ff  <= run_begin_in;
      mark_start_ff <= mark_start_in;
      mark_last_ff  <= mark_last_in;
      mark_val_ff   <= mark_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_alloc_base = rsp_start_ff;

endmodule
